>>> rtl/core/s2p_pkg.sv
// ----------------------------------------------------------------------------
// s2p_pkg
// Shared constants, tables and types for the speed-to-PWM interpolator:
// breakpoint speeds, duties, segment slopes and the token that walks the
// compare chain.
// ----------------------------------------------------------------------------
package s2p_pkg;

  localparam int NUM_POINTS      = 23;
  localparam int NUM_SEG         = NUM_POINTS - 1;
  localparam int NUM_CELLS       = NUM_POINTS - 2;
  localparam int SPEED_FRAC_BITS = 12;
  localparam int SLOPE_FRAC_BITS = 16;

  localparam int SPEED_W = 16;
  localparam int LEVEL_W = 16;
  localparam int DUTY_W  = 16;
  localparam int SLOPE_W = 32;
  localparam int PROD_W  = SLOPE_W + SPEED_W;
  localparam int SUM_W   = PROD_W - SLOPE_FRAC_BITS + 1;
  localparam int IDX_W   = $clog2(NUM_SEG);

  // Table speeds stay below 2^(frac+5): the top speed is under 20.5 units
  localparam int SPD_W = (SPEED_FRAC_BITS + 5 > SPEED_W) ? SPEED_FRAC_BITS + 5 : SPEED_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Convert a speed in hundredths to the command format, round half up
  function automatic logic [SPD_W-1:0] spd_of(input int unsigned h);
    longint unsigned v;
    v = ((longint'(h) << SPEED_FRAC_BITS) + 50) / 100;
    return SPD_W'(v);
  endfunction

  localparam logic [SPD_W-1:0] SPD [NUM_POINTS] = '{
    spd_of(0),    spd_of(1),    spd_of(97),   spd_of(149),  spd_of(224),
    spd_of(294),  spd_of(365),  spd_of(433),  spd_of(500),  spd_of(565),
    spd_of(630),  spd_of(695),  spd_of(764),  spd_of(828),  spd_of(892),
    spd_of(954),  spd_of(1020), spd_of(1098), spd_of(1162), spd_of(1240),
    spd_of(1315), spd_of(1365), spd_of(1379)
  };

  localparam logic [DUTY_W-1:0] DUTY [NUM_POINTS] = '{
    16'd0,     16'd8000,  16'd10000, 16'd12000, 16'd15000, 16'd18000,
    16'd21000, 16'd24000, 16'd27000, 16'd30000, 16'd33000, 16'd36000,
    16'd39000, 16'd42000, 16'd45000, 16'd48000, 16'd51000, 16'd54000,
    16'd57000, 16'd60000, 16'd63000, 16'd65000, 16'd65535
  };

  // Per-segment slope, unsigned Q.16 duty per speed step
  localparam logic [SLOPE_W-1:0] SLOPE [NUM_SEG] = '{
    SLOPE_W'(((SLOPE_W'(DUTY[1]) - SLOPE_W'(DUTY[0])) << SLOPE_FRAC_BITS)
      / (SPD[1] - SPD[0])),
    SLOPE_W'(((SLOPE_W'(DUTY[2]) - SLOPE_W'(DUTY[1])) << SLOPE_FRAC_BITS)
      / (SPD[2] - SPD[1])),
    SLOPE_W'(((SLOPE_W'(DUTY[3]) - SLOPE_W'(DUTY[2])) << SLOPE_FRAC_BITS)
      / (SPD[3] - SPD[2])),
    SLOPE_W'(((SLOPE_W'(DUTY[4]) - SLOPE_W'(DUTY[3])) << SLOPE_FRAC_BITS)
      / (SPD[4] - SPD[3])),
    SLOPE_W'(((SLOPE_W'(DUTY[5]) - SLOPE_W'(DUTY[4])) << SLOPE_FRAC_BITS)
      / (SPD[5] - SPD[4])),
    SLOPE_W'(((SLOPE_W'(DUTY[6]) - SLOPE_W'(DUTY[5])) << SLOPE_FRAC_BITS)
      / (SPD[6] - SPD[5])),
    SLOPE_W'(((SLOPE_W'(DUTY[7]) - SLOPE_W'(DUTY[6])) << SLOPE_FRAC_BITS)
      / (SPD[7] - SPD[6])),
    SLOPE_W'(((SLOPE_W'(DUTY[8]) - SLOPE_W'(DUTY[7])) << SLOPE_FRAC_BITS)
      / (SPD[8] - SPD[7])),
    SLOPE_W'(((SLOPE_W'(DUTY[9]) - SLOPE_W'(DUTY[8])) << SLOPE_FRAC_BITS)
      / (SPD[9] - SPD[8])),
    SLOPE_W'(((SLOPE_W'(DUTY[10]) - SLOPE_W'(DUTY[9])) << SLOPE_FRAC_BITS)
      / (SPD[10] - SPD[9])),
    SLOPE_W'(((SLOPE_W'(DUTY[11]) - SLOPE_W'(DUTY[10])) << SLOPE_FRAC_BITS)
      / (SPD[11] - SPD[10])),
    SLOPE_W'(((SLOPE_W'(DUTY[12]) - SLOPE_W'(DUTY[11])) << SLOPE_FRAC_BITS)
      / (SPD[12] - SPD[11])),
    SLOPE_W'(((SLOPE_W'(DUTY[13]) - SLOPE_W'(DUTY[12])) << SLOPE_FRAC_BITS)
      / (SPD[13] - SPD[12])),
    SLOPE_W'(((SLOPE_W'(DUTY[14]) - SLOPE_W'(DUTY[13])) << SLOPE_FRAC_BITS)
      / (SPD[14] - SPD[13])),
    SLOPE_W'(((SLOPE_W'(DUTY[15]) - SLOPE_W'(DUTY[14])) << SLOPE_FRAC_BITS)
      / (SPD[15] - SPD[14])),
    SLOPE_W'(((SLOPE_W'(DUTY[16]) - SLOPE_W'(DUTY[15])) << SLOPE_FRAC_BITS)
      / (SPD[16] - SPD[15])),
    SLOPE_W'(((SLOPE_W'(DUTY[17]) - SLOPE_W'(DUTY[16])) << SLOPE_FRAC_BITS)
      / (SPD[17] - SPD[16])),
    SLOPE_W'(((SLOPE_W'(DUTY[18]) - SLOPE_W'(DUTY[17])) << SLOPE_FRAC_BITS)
      / (SPD[18] - SPD[17])),
    SLOPE_W'(((SLOPE_W'(DUTY[19]) - SLOPE_W'(DUTY[18])) << SLOPE_FRAC_BITS)
      / (SPD[19] - SPD[18])),
    SLOPE_W'(((SLOPE_W'(DUTY[20]) - SLOPE_W'(DUTY[19])) << SLOPE_FRAC_BITS)
      / (SPD[20] - SPD[19])),
    SLOPE_W'(((SLOPE_W'(DUTY[21]) - SLOPE_W'(DUTY[20])) << SLOPE_FRAC_BITS)
      / (SPD[21] - SPD[20])),
    SLOPE_W'(((SLOPE_W'(DUTY[22]) - SLOPE_W'(DUTY[21])) << SLOPE_FRAC_BITS)
      / (SPD[22] - SPD[21]))
  };

  // Token handed from cell to cell along the compare chain
  typedef struct packed {
    logic               vld;
    logic               fwd;
    logic [SPEED_W-1:0] speed;
    logic [IDX_W-1:0]   seg;
  } s2p_tok_t;

endpackage

>>> rtl/core/speed_to_pwm_interpolator.sv
// ----------------------------------------------------------------------------
// speed_to_pwm_interpolator
// Maps an unsigned Q4.12 speed command to a PWM compare level by linear
// interpolation over a fixed 23-point speed-to-duty table.
// ----------------------------------------------------------------------------
// Each command flows through a row of NUM_POINTS-2 compare cells (one per
// inner breakpoint), then a lookup stage, a multiply stage and the output
// register. One command enters per cycle; the whole row moves together, so
// a result held at the output stalls every stage behind it and in_ready
// drops until out_ready returns. Speeds above 13.79 saturate to level
// 65534. The level goes to level_a when spin_forward is 1 and to level_b
// otherwise, the other side reading zero.
module speed_to_pwm_interpolator
  import s2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               spin_forward,
  input  logic [SPEED_W-1:0] speed_setpoint,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] level_a,
  output logic [LEVEL_W-1:0] level_b
);

  logic             en;
  logic [SPD_W-1:0] top_spd;
  s2p_tok_t         chain [NUM_CELLS+1];

  // Move the pipeline whenever the output register is free or draining
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;
  assign top_spd  = SPD[NUM_POINTS-1];

  // Clamp the speed and start in the first segment
  always_comb begin
    chain[0].vld = in_valid;
    chain[0].fwd = spin_forward;
    chain[0].seg = '0;
    if (SPD_W'(speed_setpoint) > top_spd) begin
      chain[0].speed = top_spd[SPEED_W-1:0];
    end else begin
      chain[0].speed = speed_setpoint;
    end
  end

  // Compare chain, one cell per inner breakpoint
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    s2p_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .thresh (SPD[j+1]),
      .idx    (IDX_W'(j + 1)),
      .tok_in (chain[j]),
      .tok    (chain[j+1])
    );
  end

  s2p_interp u_interp (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tok     (chain[NUM_CELLS]),
    .out_vld (out_valid),
    .level_a (level_a),
    .level_b (level_b)
  );

endmodule

>>> rtl/core/s2p_cell.sv
// ----------------------------------------------------------------------------
// s2p_cell
// One breakpoint of the compare chain: passes the token on and raises its
// segment index when the speed lies above this cell's breakpoint.
// ----------------------------------------------------------------------------
module s2p_cell
  import s2p_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [SPD_W-1:0] thresh,
  input  logic [IDX_W-1:0] idx,
  input  s2p_tok_t         tok_in,
  output s2p_tok_t         tok
);

  s2p_tok_t tok_next;

  // Move to this segment when the speed passes the breakpoint
  always_comb begin
    tok_next = tok_in;
    if (SPD_W'(tok_in.speed) > thresh) begin
      tok_next.seg = idx;
    end
  end

  // Advance the token while the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (en) begin
      tok <= tok_next;
    end
  end

endmodule

>>> rtl/core/s2p_interp.sv
// ----------------------------------------------------------------------------
// s2p_interp
// Segment lookup, slope multiply, sum with clamp and side routing, ending in
// the output register.
// ----------------------------------------------------------------------------
module s2p_interp
  import s2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  s2p_tok_t           tok,
  output logic               out_vld,
  output logic [LEVEL_W-1:0] level_a,
  output logic [LEVEL_W-1:0] level_b
);

  logic               a_vld;
  logic               a_fwd;
  logic [DUTY_W-1:0]  a_base;
  logic [SLOPE_W-1:0] a_slope;
  logic [SPEED_W-1:0] a_diff;

  logic               b_vld;
  logic               b_fwd;
  logic [DUTY_W-1:0]  b_base;
  logic [PROD_W-1:0]  b_prod;

  logic [SPD_W-1:0]   lo_full;
  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] level;

  assign lo_full = SPD[tok.seg];

  // Look up the segment and take the offset into it
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_fwd   <= tok.fwd;
      a_base  <= DUTY[tok.seg];
      a_slope <= SLOPE[tok.seg];
      a_diff  <= tok.speed - lo_full[SPEED_W-1:0];
    end
  end

  // Multiply slope by offset
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_fwd  <= a_fwd;
      b_base <= a_base;
      b_prod <= PROD_W'(a_slope) * PROD_W'(a_diff);
    end
  end

  // Add the base duty and clamp to the level range
  always_comb begin
    sum = SUM_W'(b_base) + SUM_W'(b_prod[PROD_W-1:SLOPE_FRAC_BITS]);
    if (sum > SUM_W'(LEVEL_MAX)) begin
      level = LEVEL_MAX;
    end else begin
      level = sum[LEVEL_W-1:0];
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_a <= b_fwd ? level : '0;
      level_b <= b_fwd ? '0 : level;
    end
  end

endmodule
